// File: rtl/core/mpk_pkg.sv
// Shared types, constants and microcode ROM for the max-profit k-transactions core.
package mpk_pkg;

	localparam int BAL_W   = 32;
	localparam int PRICE_W = 16;
	localparam int LIMIT_W = 4;
	localparam int PROFIT_W = 31;

	localparam logic signed [BAL_W-1:0] HOLD_EMPTY = 32'sh8000_0000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd1;

	typedef enum logic [1:0] {
		STEP_FETCH,
		STEP_READ,
		STEP_CALC,
		STEP_EMIT
	} step_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_SLOT_LAST,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic  acc;
		logic  calc;
		logic  emit;
		cond_t cond;
		step_t nxt_t;
		step_t nxt_f;
	} uword_t;

	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		w = '{acc: 1'b1, calc: 1'b0, emit: 1'b0, cond: COND_IN_VALID,
			nxt_t: STEP_READ, nxt_f: STEP_FETCH};
		case (step)
			STEP_FETCH: w = '{acc: 1'b1, calc: 1'b0, emit: 1'b0, cond: COND_IN_VALID,
				nxt_t: STEP_READ, nxt_f: STEP_FETCH};
			STEP_READ: w = '{acc: 1'b0, calc: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
				nxt_t: STEP_CALC, nxt_f: STEP_CALC};
			STEP_CALC: w = '{acc: 1'b0, calc: 1'b1, emit: 1'b0, cond: COND_SLOT_LAST,
				nxt_t: STEP_EMIT, nxt_f: STEP_CALC};
			STEP_EMIT: w = '{acc: 1'b0, calc: 1'b0, emit: 1'b1, cond: COND_OUT_FREE,
				nxt_t: STEP_FETCH, nxt_f: STEP_EMIT};
			default: w = '{acc: 1'b1, calc: 1'b0, emit: 1'b0, cond: COND_IN_VALID,
				nxt_t: STEP_READ, nxt_f: STEP_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/mpk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/max_profit_k_transactions_core.sv
// Top level: microcoded best-profit tracker over a price stream, k transactions.
//
//  channel  | direction | word contents (lsb first)
//  ---------+-----------+-------------------------------------------------
//  cfg      | in        | cfg_data: max_transactions[3:0]
//  s_axis   | in        | tdata: price[15:0]; tuser: first_day; tlast: last_day
//  m_axis   | out       | tdata: best_profit[30:0], pad[31]; tlast: final_res
//
// An item steps through fetch, RAM read, a calc step per slot through the single
// balance RAM, and emit. Slot balances live in the RAM; per-slot valid
// bits stand in for the reset value and are cleared by reset and by first_day.
// The result sits in an output register, so the next word is fetched while it waits.
// cfg is always ready.
module max_profit_k_transactions_core #(
	parameter int MAX_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,       // max_transactions
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // price
	input  logic        s_axis_tuser,   // first_day
	input  logic        s_axis_tlast,   // last_day
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // best_profit[30:0], zero pad
	output logic        m_axis_tlast    // final_res
);

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = ((SW > mpk_pkg::LIMIT_W) ? SW : mpk_pkg::LIMIT_W) + 1;
	localparam int RW = 2 * mpk_pkg::BAL_W;
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

	mpk_pkg::step_t  step_q, step_nxt;
	mpk_pkg::uword_t uw;
	logic            cond_ok;
	logic            acc, calc, out_free, emit_go;

	logic [mpk_pkg::LIMIT_W-1:0] max_trans_q;
	logic [SW-1:0]               slot_q;
	logic [MAX_SLOTS-1:0]        vld_q;
	logic                        out_vld_q;

	logic [mpk_pkg::PRICE_W-1:0]        price_q;
	logic                               last_q;
	logic signed [mpk_pkg::BAL_W-1:0]   best_q;
	logic signed [mpk_pkg::BAL_W-1:0]   prev_free_q;
	logic [mpk_pkg::PROFIT_W-1:0]       out_profit_q;
	logic                               out_last_q;

	logic [SW-1:0]                      rd_addr;
	logic [RW-1:0]                      rd_word, wr_word;
	logic signed [mpk_pkg::BAL_W:0]     hold_old, free_old, base_bal, buy, sell, price_x;
	logic signed [mpk_pkg::BAL_W-1:0]   new_hold, new_free;
	logic                               slot_vld, in_lim;

	assign cfg_ready = 1'b1;

	// microcode sequencing
	always_comb begin
		uw = mpk_pkg::ucode_rom(step_q);
	end

	assign out_free = !out_vld_q || m_axis_tready;

	always_comb begin
		case (uw.cond)
			mpk_pkg::COND_ALWAYS:    cond_ok = 1'b1;
			mpk_pkg::COND_IN_VALID:  cond_ok = s_axis_tvalid;
			mpk_pkg::COND_SLOT_LAST: cond_ok = (slot_q == LAST_SLOT);
			mpk_pkg::COND_OUT_FREE:  cond_ok = out_free;
			default:                 cond_ok = 1'b1;
		endcase
	end

	always_comb begin
		step_nxt = cond_ok ? uw.nxt_t : uw.nxt_f;
	end

	always_comb begin
		s_axis_tready = uw.acc;
		acc           = uw.acc && s_axis_tvalid;
		calc          = uw.calc;
		emit_go       = uw.emit && out_free;
	end

	// datapath
	assign rd_addr  = calc ? slot_q + SW'(1) : slot_q;
	assign slot_vld = vld_q[slot_q];
	assign price_x  = $signed({{(mpk_pkg::BAL_W + 1 - mpk_pkg::PRICE_W){1'b0}}, price_q});

	always_comb begin
		hold_old = slot_vld ? {rd_word[RW-1], rd_word[RW-1:mpk_pkg::BAL_W]}
			: {mpk_pkg::HOLD_EMPTY[mpk_pkg::BAL_W-1], mpk_pkg::HOLD_EMPTY};
		free_old = slot_vld ? {rd_word[mpk_pkg::BAL_W-1], rd_word[mpk_pkg::BAL_W-1:0]}
			: '0;
		base_bal = (slot_q == '0) ? '0 : {prev_free_q[mpk_pkg::BAL_W-1], prev_free_q};
		buy      = base_bal - price_x;
		sell     = hold_old + price_x;
		new_hold = (buy > hold_old) ? buy[mpk_pkg::BAL_W-1:0] : hold_old[mpk_pkg::BAL_W-1:0];
		new_free = (sell > free_old) ? sell[mpk_pkg::BAL_W-1:0] : free_old[mpk_pkg::BAL_W-1:0];
		in_lim   = CW'(slot_q) < CW'(max_trans_q);
	end

	assign wr_word = {new_hold, new_free};

	mpk_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_SLOTS)
	) u_bal_ram (
		.clk   (clk),
		.we    (calc),
		.waddr (slot_q),
		.wdata (wr_word),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= mpk_pkg::STEP_FETCH;
			max_trans_q <= mpk_pkg::LIMIT_RESET;
			slot_q      <= '0;
			vld_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (cfg_valid) begin
				max_trans_q <= cfg_data;
			end
			if (acc) begin
				slot_q <= '0;
				if (s_axis_tuser) begin
					vld_q <= '0;
				end
			end else if (calc) begin
				slot_q        <= slot_q + SW'(1);
				vld_q[slot_q] <= 1'b1;
			end
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc) begin
			price_q <= s_axis_tdata;
			last_q  <= s_axis_tlast;
			best_q  <= '0;
		end else if (calc) begin
			prev_free_q <= free_old[mpk_pkg::BAL_W-1:0];
			if (in_lim && (new_free > best_q)) begin
				best_q <= new_free;
			end
		end
		if (emit_go) begin
			// best_q is never negative, so it fits the output range as is
			out_profit_q <= best_q[mpk_pkg::PROFIT_W-1:0];
			out_last_q   <= last_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_profit_q};
	assign m_axis_tlast  = out_last_q;

endmodule
